// File: rtl/core/eirc_pkg.sv
// eirc_pkg: shared sizes, codes and types of the excluded rank compactor.
// Used by every module in rtl/core but eirc_ram; depends on nothing.
package eirc_pkg;

  localparam int MAX_EXCLUDED = 64;
  localparam int RANK_BITS    = 20;
  localparam int IDX_W        = $clog2(MAX_EXCLUDED);
  localparam int CNT_W        = $clog2(MAX_EXCLUDED + 1);
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [RANK_BITS-1:0] rank_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [STATUS_W-1:0]  status_t;

  localparam mode_t MODE_CLEAR  = 2'd0;
  localparam mode_t MODE_LOAD   = 2'd1;
  localparam mode_t MODE_DENSE  = 2'd2;
  localparam mode_t MODE_SPARSE = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EXCLUDED = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_DUP      = 2'd3;

  localparam rank_t RANK_MAX = {RANK_BITS{1'b1}};
  localparam cnt_t  CNT_FULL = cnt_t'(MAX_EXCLUDED);

  typedef struct packed {
    mode_t mode;
    rank_t rank;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_out_t;

endpackage

// File: rtl/core/excluded_id_rank_compactor.sv
// excluded_id_rank_compactor: top level; command queue front end feeding the
// table walker. Depends on eirc_pkg, eirc_front, eirc_back (and eirc_ram).
// The walker takes one queued word at a time, popping it only while idle;
// clears are answered straight from idle, queries and loads walk the table.
// busy rises while the two-word queue is full; the receiver cannot stall.
// Reset empties the queue and the table count; no clearing pass.
module excluded_id_rank_compactor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  eirc_pkg::mode_t     in_mode,
  input  eirc_pkg::rank_t     in_rank_value,
  output logic                out_valid,
  output eirc_pkg::rank_t     out_rank_result,
  output eirc_pkg::status_t   out_status,
  output eirc_pkg::cnt_t      out_excluded_count
);
  import eirc_pkg::*;

  queue_out_t q_out;
  logic       q_pop;

  eirc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_rank_value (in_rank_value),
    .q_out         (q_out),
    .q_pop         (q_pop)
  );

  eirc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_out              (q_out),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_rank_result    (out_rank_result),
    .out_status         (out_status),
    .out_excluded_count (out_excluded_count)
  );

endmodule

// File: rtl/core/eirc_ram.sv
// eirc_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
module eirc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/eirc_front.sv
// eirc_front: accepts command words and holds them in a short queue.
// Depends on eirc_pkg.
module eirc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  eirc_pkg::mode_t      in_mode,
  input  eirc_pkg::rank_t      in_rank_value,
  output eirc_pkg::queue_out_t q_out,
  input  logic                 q_pop
);
  import eirc_pkg::*;

  cmd_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QLVL_W-1:0] level_r, level_nxt;
  logic              push;
  cmd_t              new_cmd;

  assign busy      = (level_r == QLVL_W'(QUEUE_DEPTH));
  assign push      = start && !busy;
  assign new_cmd   = '{mode: in_mode, rank: in_rank_value};
  assign q_out.valid = (level_r != '0);
  assign q_out.cmd   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    priority if (push && !q_pop) begin
      level_nxt = QLVL_W'(level_r + 1'b1);
    end else if (q_pop && !push) begin
      level_nxt = QLVL_W'(level_r - 1'b1);
    end else begin
      level_nxt = level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= new_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> level_r != '0)
    else $error("pop from empty command queue");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= QLVL_W'(QUEUE_DEPTH))
    else $error("command queue level overflow");

  a_push_level: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop) |=> level_r == QLVL_W'($past(level_r) + 1'b1))
    else $error("queue level did not advance on push");
`endif

endmodule

// File: rtl/core/eirc_back.sv
// eirc_back: walks the excluded rank table one entry per cycle to run loads
// and queries, and empties the count on clears. Depends on eirc_pkg and eirc_ram.
module eirc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  eirc_pkg::queue_out_t     q_out,
  output logic                     q_pop,
  output logic                     out_valid,
  output eirc_pkg::rank_t          out_rank_result,
  output eirc_pkg::status_t        out_status,
  output eirc_pkg::cnt_t           out_excluded_count
);
  import eirc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_INS   = 2'd3;

  logic [1:0] state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       idx_r, idx_nxt;
  cnt_t       pos_r, pos_nxt;
  mode_t      mode_r, mode_nxt;
  rank_t      rank_r, rank_nxt;
  rank_t      acc_r, acc_nxt;

  logic       out_valid_r, out_valid_nxt;
  rank_t      out_rank_r, out_rank_nxt;
  status_t    out_status_r, out_status_nxt;
  cnt_t       out_count_r, out_count_nxt;

  logic       ram_we;
  idx_t       ram_waddr;
  rank_t      ram_wdata;
  idx_t       ram_raddr;
  rank_t      ram_rdata;

  logic       hit;
  cnt_t       idx_inc, idx_dec, cnt_dec, cnt_inc;

  eirc_ram #(
    .WIDTH (RANK_BITS),
    .DEPTH (MAX_EXCLUDED)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hit     = (idx_r < count_r);
  assign idx_inc = cnt_t'(idx_r + 1'b1);
  assign idx_dec = cnt_t'(idx_r - 1'b1);
  assign cnt_dec = cnt_t'(count_r - 1'b1);
  assign cnt_inc = cnt_t'(count_r + 1'b1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    mode_nxt       = mode_r;
    rank_nxt       = rank_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = 1'b0;
    out_rank_nxt   = '0;
    out_status_nxt = ST_OK;
    out_count_nxt  = count_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = idx_inc[IDX_W-1:0];
    ram_wdata      = ram_rdata;
    ram_raddr      = idx_inc[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = '0;
        if (q_out.valid) begin
          q_pop    = 1'b1;
          mode_nxt = q_out.cmd.mode;
          rank_nxt = q_out.cmd.rank;
          acc_nxt  = q_out.cmd.rank;
          idx_nxt  = '0;
          if (q_out.cmd.mode == MODE_CLEAR) begin
            count_nxt     = '0;
            out_count_nxt = '0;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        unique case (mode_r)
          MODE_LOAD: begin
            if (hit && ram_rdata < rank_r) begin
              idx_nxt = idx_inc;
            end else if (hit && ram_rdata == rank_r) begin
              out_status_nxt = ST_DUP;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else if (count_r == CNT_FULL) begin
              out_status_nxt = ST_FULL;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              pos_nxt = idx_r;
              if (idx_r == count_r) begin
                state_nxt = S_INS;
              end else begin
                ram_raddr = cnt_dec[IDX_W-1:0];
                idx_nxt   = cnt_dec;
                state_nxt = S_SHIFT;
              end
            end
          end
          MODE_DENSE: begin
            if (hit && ram_rdata < rank_r) begin
              idx_nxt = idx_inc;
            end else begin
              out_rank_nxt   = rank_t'(rank_r - rank_t'(idx_r));
              out_status_nxt = (hit && ram_rdata == rank_r) ? ST_EXCLUDED : ST_OK;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end
          end
          MODE_SPARSE: begin
            if (hit && acc_r >= ram_rdata) begin
              if (acc_r == RANK_MAX) begin
                out_rank_nxt  = RANK_MAX;
                out_valid_nxt = 1'b1;
                state_nxt     = S_IDLE;
              end else begin
                acc_nxt = rank_t'(acc_r + 1'b1);
                idx_nxt = idx_inc;
              end
            end else begin
              out_rank_nxt  = acc_r;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          MODE_CLEAR: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_inc[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_dec[IDX_W-1:0];
        if (idx_r == pos_r) begin
          state_nxt = S_INS;
        end else begin
          idx_nxt = idx_dec;
        end
      end

      S_INS: begin
        ram_we        = 1'b1;
        ram_waddr     = pos_r[IDX_W-1:0];
        ram_wdata     = rank_r;
        count_nxt     = cnt_inc;
        out_count_nxt = cnt_inc;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    mode_r       <= mode_nxt;
    rank_r       <= rank_nxt;
    acc_r        <= acc_nxt;
    out_rank_r   <= out_rank_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_rank_result    = out_rank_r;
  assign out_status         = out_status_r;
  assign out_excluded_count = out_count_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("excluded count above table depth");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SHIFT || state_r == S_INS))
    else $error("table write outside insert phase");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_DUP || out_status_r == ST_FULL))
      |-> out_count_r == count_r)
    else $error("rejected load changed the count");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_SCAN || out_valid_r))
    else $error("popped word neither walked nor answered");
`endif

endmodule
